FILE: src/clsr_pkg.sv
// clsr_pkg: shared types, constants and the control store for the character-LCD
// shadow-refresh block. Used by char_lcd_shadow_refresh, clsr_checker and tb.
// No dependencies.
package clsr_pkg;

  // display geometry
  localparam int COLUMNS = 16;
  localparam int ROWS    = 2;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int CELL_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int PC_W    = 5;

  // operation codes of an input word
  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_REFRESH = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;
  localparam logic [1:0] FUNC_INIT    = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_NIBBLE = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // register select
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // controller command bytes
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_HOME         = 8'h02;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h04;
  localparam logic [7:0] CMD_DISPLAY_CTRL = 8'h08;
  localparam logic [7:0] CMD_FUNC_SET     = 8'h20;
  localparam logic [7:0] CMD_SET_ADDR     = 8'h80;
  localparam logic [7:0] ROW1_ADDR        = 8'h40;
  localparam logic [7:0] ADDR_MASK        = 8'h7f;
  localparam logic [7:0] WAKE_NIBBLE      = 8'h03;
  localparam logic [7:0] BUS4_NIBBLE      = 8'h02;
  localparam logic [7:0] SPACE_CHAR       = 8'h20;

  // input and result words
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] column;
    logic [7:0] line_index;
    logic [7:0] char_code;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       reg_select;
    logic [7:0] bus_value;
    logic       status;
    logic       last;
  } result_t;

  // control word fields
  typedef enum logic [1:0] {
    COND_NEVER,
    COND_CLEAN,
    COND_ROW0_MORE,
    COND_ROW1_MORE
  } cond_t;

  typedef enum logic [1:0] {
    SRC_CONST,
    SRC_CELL,
    SRC_STATUS
  } src_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_FILL,
    OP_CLEAN
  } op_t;

  typedef struct packed {
    logic            emit;
    src_t            src;
    logic [1:0]      kind;
    logic            rs;
    logic [7:0]      value;
    logic            load;   // capture the cell at the counter
    logic            inc;    // advance the cell counter
    cond_t           cond;   // jump when the condition holds
    logic [PC_W-1:0] target;
    logic            last;   // final result, when not jumping
    logic            fin;    // end of program, when not jumping
    op_t             op;
  } ctl_t;

  // program step addresses
  localparam logic [PC_W-1:0] PC_WRITE   = 5'd0;
  localparam logic [PC_W-1:0] PC_RCHK    = 5'd1;
  localparam logic [PC_W-1:0] PC_RCLR    = 5'd2;
  localparam logic [PC_W-1:0] PC_RHOME   = 5'd3;
  localparam logic [PC_W-1:0] PC_ROW0    = 5'd4;
  localparam logic [PC_W-1:0] PC_SETADDR = 5'd5;
  localparam logic [PC_W-1:0] PC_ROW1    = 5'd6;
  localparam logic [PC_W-1:0] PC_RNOP    = 5'd7;
  localparam logic [PC_W-1:0] PC_CLEAR   = 5'd8;
  localparam logic [PC_W-1:0] PC_INIT0   = 5'd9;
  localparam logic [PC_W-1:0] PC_INIT1   = 5'd10;
  localparam logic [PC_W-1:0] PC_INIT2   = 5'd11;
  localparam logic [PC_W-1:0] PC_INIT3   = 5'd12;
  localparam logic [PC_W-1:0] PC_INIT4   = 5'd13;
  localparam logic [PC_W-1:0] PC_INIT5   = 5'd14;
  localparam logic [PC_W-1:0] PC_INIT6   = 5'd15;
  localparam logic [PC_W-1:0] PC_INIT7   = 5'd16;

  // a step that puts out one constant on the bus
  function automatic ctl_t put_const(input logic [1:0] kind, input logic rs,
                                     input logic [7:0] value, input logic fin);
    ctl_t c;
    c        = '0;
    c.cond   = COND_NEVER;
    c.op     = OP_NONE;
    c.src    = SRC_CONST;
    c.emit   = 1'b1;
    c.kind   = kind;
    c.rs     = rs;
    c.value  = value;
    c.last   = fin;
    c.fin    = fin;
    return c;
  endfunction

  // control store
  function automatic ctl_t ustep(input logic [PC_W-1:0] pc);
    ctl_t c;
    c      = '0;
    c.cond = COND_NEVER;
    c.op   = OP_NONE;
    c.src  = SRC_CONST;
    case (pc)
      PC_WRITE: begin
        c      = put_const(KIND_STATUS, RS_CMD, 8'h00, 1'b1);
        c.src  = SRC_STATUS;
        c.op   = OP_WRITE;
      end
      PC_RCHK: begin
        c.cond   = COND_CLEAN;
        c.target = PC_RNOP;
      end
      PC_RCLR:  c = put_const(KIND_BYTE, RS_CMD, CMD_CLEAR, 1'b0);
      PC_RHOME: begin
        // prefetch cell 0
        c      = put_const(KIND_BYTE, RS_CMD, CMD_HOME, 1'b0);
        c.load = 1'b1;
        c.inc  = 1'b1;
      end
      PC_ROW0: begin
        c        = put_const(KIND_BYTE, RS_DATA, 8'h00, 1'b0);
        c.src    = SRC_CELL;
        c.load   = 1'b1;
        c.inc    = 1'b1;
        c.cond   = COND_ROW0_MORE;
        c.target = PC_ROW0;
      end
      // holds the prefetched first cell of row 1
      PC_SETADDR: c = put_const(KIND_BYTE, RS_CMD, CMD_SET_ADDR | (ROW1_ADDR & ADDR_MASK),
                                1'b0);
      PC_ROW1: begin
        c        = put_const(KIND_BYTE, RS_DATA, 8'h00, 1'b1);
        c.src    = SRC_CELL;
        c.load   = 1'b1;
        c.inc    = 1'b1;
        c.cond   = COND_ROW1_MORE;
        c.target = PC_ROW1;
        c.op     = OP_CLEAN;
      end
      PC_RNOP:  c.fin = 1'b1;
      PC_CLEAR: begin
        c    = put_const(KIND_BYTE, RS_CMD, CMD_CLEAR, 1'b1);
        c.op = OP_FILL;
      end
      PC_INIT0: c = put_const(KIND_NIBBLE, RS_CMD, WAKE_NIBBLE, 1'b0);
      PC_INIT1: c = put_const(KIND_NIBBLE, RS_CMD, WAKE_NIBBLE, 1'b0);
      PC_INIT2: c = put_const(KIND_NIBBLE, RS_CMD, WAKE_NIBBLE, 1'b0);
      PC_INIT3: c = put_const(KIND_NIBBLE, RS_CMD, BUS4_NIBBLE, 1'b0);
      PC_INIT4: c = put_const(KIND_BYTE, RS_CMD, CMD_FUNC_SET | 8'h08, 1'b0);
      PC_INIT5: c = put_const(KIND_BYTE, RS_CMD, CMD_DISPLAY_CTRL | 8'h04, 1'b0);
      PC_INIT6: c = put_const(KIND_BYTE, RS_CMD, CMD_ENTRY_MODE | 8'h02, 1'b0);
      PC_INIT7: c = put_const(KIND_BYTE, RS_CMD, CMD_CLEAR, 1'b1);
      default:  c.fin = 1'b1;
    endcase
    return c;
  endfunction

  // program entry per operation
  function automatic logic [PC_W-1:0] entry_pc(input logic [1:0] func);
    logic [PC_W-1:0] p;
    case (func)
      FUNC_WRITE:   p = PC_WRITE;
      FUNC_REFRESH: p = PC_RCHK;
      FUNC_CLEAR:   p = PC_CLEAR;
      FUNC_INIT:    p = PC_INIT0;
      default:      p = PC_RNOP;
    endcase
    return p;
  endfunction

endpackage

FILE: src/char_lcd_shadow_refresh.sv
// char_lcd_shadow_refresh: character-LCD front end with a shadow store of the
// screen, run by a small microprogram. Depends on clsr_pkg.
//
//   port      dir  width      role
//   start     in   1          new command word offered
//   busy      out  1          command word not taken while high
//   command   in   cmd_t      func, column, line_index, char_code
//   strobe    out  1          result word on result this cycle
//   result    out  result_t   kind, reg_select, bus_value, status, last
//
// One control-store step per cycle, at most one result word per step. A word is
// taken at a clock edge with start high and busy low; results follow through the
// registered strobe and result, each shown for one cycle, and busy drops with the last one.
// Reset (rst, synchronous) empties the store to zeros and the dirty flag at once.
// The receiver cannot stall.
module char_lcd_shadow_refresh (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  clsr_pkg::cmd_t    command,
  output logic             strobe,
  output clsr_pkg::result_t result
);

  clsr_pkg::cmd_t                  in_q;
  logic                            running;
  logic [clsr_pkg::PC_W-1:0]       pc;
  logic [clsr_pkg::PC_W-1:0]       pc_next;
  logic [clsr_pkg::CNT_W-1:0]      cnt;
  logic                            dirty;
  logic [7:0]                      cell_mem [clsr_pkg::CELLS];
  logic [clsr_pkg::CELLS-1:0]      cell_ok;
  logic [7:0]                      fill_byte;
  logic [7:0]                      rd_q;
  clsr_pkg::ctl_t                  ctl;
  logic                            cond_hit;
  logic                            take_jump;
  logic                            err;
  logic [8:0]                      wr_sum;
  logic [clsr_pkg::CELL_W-1:0]     wr_addr;
  logic [clsr_pkg::CELL_W-1:0]     rd_addr;
  logic                            rd_en;
  logic                            wr_en;
  clsr_pkg::result_t               res_next;

  assign busy = running;
  assign ctl  = clsr_pkg::ustep(pc);

  // position check and cell address of a write
  assign err = (in_q.column >= 8'(clsr_pkg::COLUMNS)) ||
               (in_q.line_index >= 8'(clsr_pkg::ROWS));
  assign wr_sum  = {1'b0, in_q.column} +
                   (in_q.line_index[0] ? 9'(clsr_pkg::COLUMNS) : 9'd0);
  assign wr_addr = wr_sum[clsr_pkg::CELL_W-1:0];
  assign wr_en   = running && (ctl.op == clsr_pkg::OP_WRITE) && !err;

  // prefetch address, guarded past the end of the store
  assign rd_addr = cnt[clsr_pkg::CELL_W-1:0];
  assign rd_en   = running && ctl.load && (cnt < clsr_pkg::CNT_W'(clsr_pkg::CELLS));

  // branch condition
  always_comb begin
    case (ctl.cond)
      clsr_pkg::COND_NEVER:     cond_hit = 1'b0;
      clsr_pkg::COND_CLEAN:     cond_hit = !dirty;
      clsr_pkg::COND_ROW0_MORE: cond_hit = cnt != clsr_pkg::CNT_W'(clsr_pkg::COLUMNS);
      clsr_pkg::COND_ROW1_MORE: cond_hit = cnt != clsr_pkg::CNT_W'(clsr_pkg::CELLS);
      default:                  cond_hit = 1'b0;
    endcase
    take_jump = cond_hit;
    pc_next   = take_jump ? ctl.target : pc + clsr_pkg::PC_W'(1);
  end

  // result word of the current step
  always_comb begin
    res_next            = '0;
    res_next.kind       = ctl.kind;
    res_next.reg_select = ctl.rs;
    res_next.last       = ctl.last && !take_jump;
    case (ctl.src)
      clsr_pkg::SRC_CONST:  res_next.bus_value = ctl.value;
      clsr_pkg::SRC_CELL:   res_next.bus_value = rd_q;
      clsr_pkg::SRC_STATUS: res_next.status    = err;
      default:              res_next.bus_value = ctl.value;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc      <= clsr_pkg::PC_RNOP;
      cnt     <= '0;
    end else if (!running) begin
      if (start) begin
        running <= 1'b1;
        pc      <= clsr_pkg::entry_pc(command.func);
        cnt     <= '0;
      end
    end else begin
      pc <= pc_next;
      if (ctl.inc) begin
        cnt <= cnt + clsr_pkg::CNT_W'(1);
      end
      if (ctl.fin && !take_jump) begin
        running <= 1'b0;
      end
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (!running && start) begin
      in_q <= command;
    end
  end

  // dirty flag
  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= 1'b0;
    end else if (wr_en) begin
      dirty <= 1'b1;
    end else if (running && ctl.op == clsr_pkg::OP_CLEAN) begin
      dirty <= 1'b0;
    end
  end

  // cell valid bits and fill value; an unwritten cell reads as the fill value
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_ok   <= '0;
      fill_byte <= 8'h00;
    end else if (running && ctl.op == clsr_pkg::OP_FILL) begin
      cell_ok   <= '0;
      fill_byte <= clsr_pkg::SPACE_CHAR;
    end else if (wr_en) begin
      cell_ok[wr_addr] <= 1'b1;
    end
  end

  // cell store write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_mem[wr_addr] <= in_q.char_code;
    end
  end

  // cell store read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= cell_ok[rd_addr] ? cell_mem[rd_addr] : fill_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= running && ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (running && ctl.emit) begin
      result <= res_next;
    end
  end

endmodule

FILE: src/clsr_checker.sv
// clsr_checker: port-level checks on char_lcd_shadow_refresh, attached by bind.
// Depends on clsr_pkg and char_lcd_shadow_refresh.
module clsr_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input clsr_pkg::cmd_t    command,
  input logic             strobe,
  input clsr_pkg::result_t result
);

  // a taken word makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after a command word was taken");

  // results only come out of a command in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result word without a command in progress");

  // the final word releases the block
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> !busy)
    else $error("block still busy after the final result word");

  // an error is a lone status word
  a_err_status: assert property (@(posedge clk) disable iff (rst)
    strobe && result.status |-> result.last && result.kind == clsr_pkg::KIND_STATUS &&
      command.func == command.func)
    else $error("position error outside a final status word");

endmodule

bind char_lcd_shadow_refresh clsr_checker u_clsr_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .command (command),
  .strobe  (strobe),
  .result  (result)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for char_lcd_shadow_refresh, with a scoreboard class that predicts
// every result word from the accepted command words. Depends on clsr_pkg and the block.
module tb;

  // option bits of the set-up commands
  localparam logic [7:0] FS_TWO_LINE   = 8'h08;
  localparam logic [7:0] DC_DISPLAY_ON = 8'h04;
  localparam logic [7:0] EM_INCREMENT  = 8'h02;
  localparam logic [7:0] ZERO_BYTE     = 8'h00;
  localparam int         RANDOM_WORDS  = 420;
  localparam int         DRAIN_CYCLES  = 40;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  clsr_pkg::cmd_t    command;
  logic              strobe;
  clsr_pkg::result_t result;

  char_lcd_shadow_refresh uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .command (command),
    .strobe  (strobe),
    .result  (result)
  );

  // shadow copy of the screen and queue of bus words still to come
  class lcd_stream_board;
    logic [7:0]        cells [clsr_pkg::CELLS];
    bit                dirty;
    clsr_pkg::result_t pending_words [$];
    int                mismatches;

    function new();
      foreach (cells[i]) cells[i] = ZERO_BYTE;
      dirty      = 1'b0;
      mismatches = 0;
    endfunction

    function void queue_word(logic [1:0] kind, logic rs, logic [7:0] value, logic status,
                             logic last);
      clsr_pkg::result_t w;
      w.kind       = kind;
      w.reg_select = rs;
      w.bus_value  = value;
      w.status     = status;
      w.last       = last;
      pending_words.push_back(w);
    endfunction

    // expected words of one accepted command word
    function void take_command(clsr_pkg::cmd_t c);
      case (c.func)
        clsr_pkg::FUNC_WRITE: begin
          if (c.column >= clsr_pkg::COLUMNS || c.line_index >= clsr_pkg::ROWS) begin
            queue_word(clsr_pkg::KIND_STATUS, clsr_pkg::RS_CMD, ZERO_BYTE, 1'b1, 1'b1);
          end else begin
            cells[int'(c.line_index) * clsr_pkg::COLUMNS + int'(c.column)] = c.char_code;
            dirty = 1'b1;
            queue_word(clsr_pkg::KIND_STATUS, clsr_pkg::RS_CMD, ZERO_BYTE, 1'b0, 1'b1);
          end
        end
        clsr_pkg::FUNC_REFRESH: begin
          // a clean store puts nothing on the bus
          if (dirty) begin
            queue_word(clsr_pkg::KIND_BYTE, clsr_pkg::RS_CMD, clsr_pkg::CMD_CLEAR, 1'b0, 1'b0);
            queue_word(clsr_pkg::KIND_BYTE, clsr_pkg::RS_CMD, clsr_pkg::CMD_HOME, 1'b0, 1'b0);
            for (int j = 0; j < clsr_pkg::COLUMNS; j++)
              queue_word(clsr_pkg::KIND_BYTE, clsr_pkg::RS_DATA, cells[j], 1'b0, 1'b0);
            queue_word(clsr_pkg::KIND_BYTE, clsr_pkg::RS_CMD,
                       clsr_pkg::CMD_SET_ADDR | (clsr_pkg::ROW1_ADDR & clsr_pkg::ADDR_MASK),
                       1'b0, 1'b0);
            for (int j = 0; j < clsr_pkg::COLUMNS; j++)
              queue_word(clsr_pkg::KIND_BYTE, clsr_pkg::RS_DATA, cells[clsr_pkg::COLUMNS + j],
                         1'b0, j == clsr_pkg::COLUMNS - 1);
            dirty = 1'b0;
          end
        end
        clsr_pkg::FUNC_CLEAR: begin
          // dirty flag stays as it is
          foreach (cells[i]) cells[i] = clsr_pkg::SPACE_CHAR;
          queue_word(clsr_pkg::KIND_BYTE, clsr_pkg::RS_CMD, clsr_pkg::CMD_CLEAR, 1'b0, 1'b1);
        end
        default: begin
          queue_word(clsr_pkg::KIND_NIBBLE, clsr_pkg::RS_CMD, clsr_pkg::WAKE_NIBBLE, 1'b0, 1'b0);
          queue_word(clsr_pkg::KIND_NIBBLE, clsr_pkg::RS_CMD, clsr_pkg::WAKE_NIBBLE, 1'b0, 1'b0);
          queue_word(clsr_pkg::KIND_NIBBLE, clsr_pkg::RS_CMD, clsr_pkg::WAKE_NIBBLE, 1'b0, 1'b0);
          queue_word(clsr_pkg::KIND_NIBBLE, clsr_pkg::RS_CMD, clsr_pkg::BUS4_NIBBLE, 1'b0, 1'b0);
          queue_word(clsr_pkg::KIND_BYTE, clsr_pkg::RS_CMD,
                     clsr_pkg::CMD_FUNC_SET | FS_TWO_LINE, 1'b0, 1'b0);
          queue_word(clsr_pkg::KIND_BYTE, clsr_pkg::RS_CMD,
                     clsr_pkg::CMD_DISPLAY_CTRL | DC_DISPLAY_ON, 1'b0, 1'b0);
          queue_word(clsr_pkg::KIND_BYTE, clsr_pkg::RS_CMD,
                     clsr_pkg::CMD_ENTRY_MODE | EM_INCREMENT, 1'b0, 1'b0);
          queue_word(clsr_pkg::KIND_BYTE, clsr_pkg::RS_CMD, clsr_pkg::CMD_CLEAR, 1'b0, 1'b1);
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    // compare one result word with the oldest expected one
    task check_word(clsr_pkg::result_t got);
      clsr_pkg::result_t want;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got));
        return;
      end
      want = pending_words.pop_front();
      if (got.kind != want.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.reg_select != want.reg_select)
        report_mismatch($sformatf("reg_select %0d, expected %0d", got.reg_select,
                                  want.reg_select));
      if (got.bus_value != want.bus_value)
        report_mismatch($sformatf("bus_value %h, expected %h", got.bus_value, want.bus_value));
      if (got.status != want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.last != want.last)
        report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
    endtask
  endclass

  lcd_stream_board board;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #1000000;
    $display("char_lcd_shadow_refresh regression: fail");
    $finish;
  end

  // sample accepted command words and result words
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) board.check_word(result);
      if (start && !busy) board.take_command(command);
    end
  end

  // idle length after a word: mostly none or short, now and then long
  function automatic int pick_gap(bit no_idle);
    int r;
    r = int'($urandom_range(0, 99));
    if (no_idle || r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 4));
    return int'($urandom_range(10, 60));
  endfunction

  // offer one word, hold it until taken, then idle for the picked gap, which may be none
  task send_word(clsr_pkg::cmd_t c, bit no_idle);
    int gap;
    start   <= 1'b1;
    command <= c;
    do @(posedge clk); while (busy);
    gap = pick_gap(no_idle);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task send_fields(logic [1:0] func, logic [7:0] col, logic [7:0] row, logic [7:0] ch);
    clsr_pkg::cmd_t c;
    c.func       = func;
    c.column     = col;
    c.line_index = row;
    c.char_code  = ch;
    send_word(c, 1'b0);
  endtask

  // random word: mostly in-range writes so refreshes carry content
  function automatic clsr_pkg::cmd_t random_word();
    clsr_pkg::cmd_t c;
    int             r;
    c.func       = clsr_pkg::FUNC_WRITE;
    c.column     = 8'($urandom_range(0, 255));
    c.line_index = 8'($urandom_range(0, 255));
    c.char_code  = 8'($urandom_range(0, 255));
    r = int'($urandom_range(0, 99));
    if (r < 62) begin
      c.column     = 8'($urandom_range(0, clsr_pkg::COLUMNS - 1));
      c.line_index = 8'($urandom_range(0, clsr_pkg::ROWS - 1));
    end else if (r < 72) begin
      if ($urandom_range(0, 1) != 0) c.column = 8'($urandom_range(clsr_pkg::COLUMNS, 255));
      else c.line_index = 8'($urandom_range(clsr_pkg::ROWS, 255));
    end else if (r < 86) begin
      c.func = clsr_pkg::FUNC_REFRESH;
    end else if (r < 93) begin
      c.func = clsr_pkg::FUNC_CLEAR;
    end else begin
      c.func = clsr_pkg::FUNC_INIT;
    end
    return c;
  endfunction

  // stimulus
  initial begin
    board   = new();
    rst     = 1'b1;
    start   = 1'b0;
    command = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: init, refresh of the clean store after reset, corner cells, bad positions
    send_fields(clsr_pkg::FUNC_INIT, 8'h00, 8'h00, 8'h00);
    send_fields(clsr_pkg::FUNC_REFRESH, 8'hff, 8'hff, 8'hff);
    send_fields(clsr_pkg::FUNC_WRITE, 8'd0, 8'd0, 8'h00);
    send_fields(clsr_pkg::FUNC_WRITE, 8'd15, 8'd1, 8'hff);
    send_fields(clsr_pkg::FUNC_WRITE, 8'd16, 8'd0, 8'h41);
    send_fields(clsr_pkg::FUNC_WRITE, 8'd0, 8'd2, 8'h42);
    send_fields(clsr_pkg::FUNC_WRITE, 8'd255, 8'd255, 8'haa);
    send_fields(clsr_pkg::FUNC_WRITE, 8'd15, 8'd0, 8'h55);
    send_fields(clsr_pkg::FUNC_WRITE, 8'd0, 8'd1, 8'h80);
    // dirty refresh shows reset zeros, second one finds the store clean
    send_fields(clsr_pkg::FUNC_REFRESH, 8'h00, 8'h00, 8'h00);
    send_fields(clsr_pkg::FUNC_REFRESH, 8'h00, 8'h00, 8'h00);
    // clear of a clean store keeps it clean
    send_fields(clsr_pkg::FUNC_CLEAR, 8'hff, 8'hff, 8'hff);
    send_fields(clsr_pkg::FUNC_REFRESH, 8'h00, 8'h00, 8'h00);
    // clear after a write keeps it dirty, refresh shows spaces
    send_fields(clsr_pkg::FUNC_WRITE, 8'd7, 8'd1, 8'h7e);
    send_fields(clsr_pkg::FUNC_CLEAR, 8'h00, 8'h00, 8'h00);
    send_fields(clsr_pkg::FUNC_REFRESH, 8'h00, 8'h00, 8'h00);
    send_fields(clsr_pkg::FUNC_INIT, 8'hff, 8'hff, 8'hff);
    send_fields(clsr_pkg::FUNC_WRITE, 8'd15, 8'd255, 8'h01);
    send_fields(clsr_pkg::FUNC_WRITE, 8'd128, 8'd1, 8'h01);

    // random words, with stretches of back-to-back offers
    for (int i = 0; i < RANDOM_WORDS; i++)
      send_word(random_word(), ((i / 40) % 4) == 2);
    start <= 1'b0;

    // drain, then let any stray words show up
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending_words.size() == 0) begin
      $display("char_lcd_shadow_refresh regression: pass");
    end else begin
      $display("char_lcd_shadow_refresh regression: fail");
    end
    $finish;
  end

endmodule
